@@ src/software_timer_slot_table_assert.svh @@
`ifndef SOFTWARE_TIMER_SLOT_TABLE_ASSERT_SVH
`define SOFTWARE_TIMER_SLOT_TABLE_ASSERT_SVH

// same-cycle implication
`define SW_TMR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sw_tmr assertion failed");

// next-cycle implication
`define SW_TMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sw_tmr assertion failed");

`endif

@@ src/sw_tmr_pkg.sv @@
package sw_tmr_pkg;

   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] RESULT_CAP = 4'd8;

   localparam logic [2:0] KIND_TICK    = 3'd0;
   localparam logic [2:0] KIND_ADD_PER = 3'd1;
   localparam logic [2:0] KIND_ADD_TMO = 3'd2;
   localparam logic [2:0] KIND_STOP    = 3'd3;
   localparam logic [2:0] KIND_RUN     = 3'd4;

   localparam logic [2:0] EV_ADDED      = 3'd0;
   localparam logic [2:0] EV_ADD_REJECT = 3'd1;
   localparam logic [2:0] EV_STOPPED    = 3'd2;
   localparam logic [2:0] EV_STOP_MISS  = 3'd3;
   localparam logic [2:0] EV_TIMEOUT    = 3'd4;
   localparam logic [2:0] EV_PERIODIC   = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic hb_valid;
      logic out_free;
   } status_type;

endpackage

@@ src/sw_tmr_ctrl.sv @@
`include "software_timer_slot_table_assert.svh"

module sw_tmr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sw_tmr_pkg::status_type status,
   output sw_tmr_pkg::cmd_type    cmd
);

   sw_tmr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sw_tmr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sw_tmr_pkg::ST_IDLE: begin
            if (req_valid) state_in = sw_tmr_pkg::ST_SCAN;
         end
         sw_tmr_pkg::ST_SCAN: begin
            if (status.scan_done) state_in = sw_tmr_pkg::ST_FINISH;
         end
         sw_tmr_pkg::ST_FINISH: begin
            state_in = sw_tmr_pkg::ST_FLUSH;
         end
         sw_tmr_pkg::ST_FLUSH: begin
            if (!status.hb_valid || status.out_free) state_in = sw_tmr_pkg::ST_IDLE;
         end
         default: begin
            state_in = sw_tmr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      cmd        = '0;
      case (state_ff)
         sw_tmr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         sw_tmr_pkg::ST_SCAN:   cmd.scan   = 1'b1;
         sw_tmr_pkg::ST_FINISH: cmd.finish = 1'b1;
         sw_tmr_pkg::ST_FLUSH:  cmd.flush  = 1'b1;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   `SW_TMR_ASSERT_NOW(a_idle_hb_empty, clock, reset, state_ff == sw_tmr_pkg::ST_IDLE, !status.hb_valid)

endmodule

@@ src/sw_tmr_dp.sv @@
`include "software_timer_slot_table_assert.svh"

module sw_tmr_dp #(
   parameter int SLOTS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sw_tmr_pkg::cmd_type           cmd,
   output sw_tmr_pkg::status_type        status,
   input  logic [2:0]                    req_kind,
   input  logic [31:0]                   req_period,
   input  logic [7:0]                    req_handler_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_event_res,
   output logic [$clog2(SLOTS+1)-1:0]    rsp_slot,
   output logic [7:0]                    rsp_fired_id,
   output logic                          rsp_last
);

   localparam int CW = $clog2(SLOTS + 1);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [CW-1:0] SLOT_NONE = CW'(SLOTS);

   logic [7:0]  owner_mem [SLOTS];
   logic [31:0] per_mem   [SLOTS];
   logic [31:0] ref_mem   [SLOTS];
   logic [7:0]  owner_rd_ff;
   logic [31:0] per_rd_ff;
   logic [31:0] ref_rd_ff;

   logic [2:0]  kind_ff, kind_in;
   logic [31:0] per_ff, per_in;
   logic [7:0]  id_ff, id_in;
   logic [31:0] tick_ff, tick_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] pend_ff, pend_in;
   logic [SLOTS-1:0] tmo_ff, tmo_in;

   logic [CW-1:0] idx_ff, idx_in;
   logic          ev_valid_ff, ev_valid_in;
   logic [IW-1:0] ev_idx_ff, ev_idx_in;
   logic          found_ff, found_in;
   logic [sw_tmr_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic          hb_valid_ff, hb_valid_in;
   logic [2:0]    hb_event_ff, hb_event_in;
   logic [CW-1:0] hb_slot_ff, hb_slot_in;
   logic [7:0]    hb_id_ff, hb_id_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_event_ff, rsp_event_in;
   logic [CW-1:0] rsp_slot_ff, rsp_slot_in;
   logic [7:0]    rsp_id_ff, rsp_id_in;
   logic          rsp_last_ff, rsp_last_in;

   logic        out_free;
   logic        cur_v, cur_pend, cur_tmo;
   logic [31:0] elapsed;
   logic        due;
   logic        res_hit;
   logic [2:0]  res_event;
   logic [7:0]  res_id;
   logic        ref_we;
   logic [31:0] ref_wd;
   logic        add_hit, stop_hit, pend_set, pend_clr;
   logic        ev_go, ev_fire, advance, rd_issue;
   logic        scan_push, flush_push;
   logic        is_add_stop;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      cur_v    = valid_ff[ev_idx_ff];
      cur_pend = pend_ff[ev_idx_ff];
      cur_tmo  = tmo_ff[ev_idx_ff];
      elapsed  = tick_ff - ref_rd_ff;
      due      = cur_v && (elapsed >= per_rd_ff);

      res_hit   = 1'b0;
      res_event = sw_tmr_pkg::EV_ADDED;
      res_id    = 8'd0;
      ref_we    = 1'b0;
      ref_wd    = 32'd0;
      add_hit   = 1'b0;
      stop_hit  = 1'b0;
      pend_set  = 1'b0;
      pend_clr  = 1'b0;

      if (ev_valid_ff) begin
         case (kind_ff)
            sw_tmr_pkg::KIND_TICK: begin
               if (due) begin
                  if (cur_tmo) begin
                     ref_we = 1'b1;
                     if (cnt_ff < sw_tmr_pkg::RESULT_CAP) begin
                        res_hit   = 1'b1;
                        res_event = sw_tmr_pkg::EV_TIMEOUT;
                        res_id    = owner_rd_ff;
                     end
                  end else if (!cur_pend) begin
                     ref_we   = 1'b1;
                     ref_wd   = tick_ff;
                     pend_set = 1'b1;
                  end
               end
            end
            sw_tmr_pkg::KIND_ADD_PER, sw_tmr_pkg::KIND_ADD_TMO: begin
               if (!found_ff && per_ff != 32'd0 && id_ff != 8'd0 && !cur_v) begin
                  add_hit   = 1'b1;
                  ref_we    = 1'b1;
                  ref_wd    = tick_ff;
                  res_hit   = 1'b1;
                  res_event = sw_tmr_pkg::EV_ADDED;
                  res_id    = id_ff;
               end
            end
            sw_tmr_pkg::KIND_STOP: begin
               if (!found_ff && id_ff != 8'd0 && cur_v && owner_rd_ff == id_ff
                   && per_rd_ff == per_ff) begin
                  stop_hit  = 1'b1;
                  res_hit   = 1'b1;
                  res_event = sw_tmr_pkg::EV_STOPPED;
                  res_id    = id_ff;
               end
            end
            sw_tmr_pkg::KIND_RUN: begin
               if (cur_pend && cur_v && cnt_ff < sw_tmr_pkg::RESULT_CAP) begin
                  pend_clr  = 1'b1;
                  res_hit   = 1'b1;
                  res_event = sw_tmr_pkg::EV_PERIODIC;
                  res_id    = owner_rd_ff;
               end
            end
            default: begin
            end
         endcase
      end

      ev_go      = !res_hit || !hb_valid_ff || out_free;
      ev_fire    = ev_valid_ff && ev_go;
      advance    = cmd.scan && (!ev_valid_ff || ev_go);
      rd_issue   = advance && (idx_ff != SLOT_NONE);
      scan_push  = ev_fire && res_hit && hb_valid_ff;
      flush_push = cmd.flush && hb_valid_ff && out_free;
      is_add_stop = (kind_ff == sw_tmr_pkg::KIND_ADD_PER) || (kind_ff == sw_tmr_pkg::KIND_ADD_TMO)
                    || (kind_ff == sw_tmr_pkg::KIND_STOP);
   end

   always_comb begin
      kind_in     = kind_ff;
      per_in      = per_ff;
      id_in       = id_ff;
      tick_in     = tick_ff;
      valid_in    = valid_ff;
      pend_in     = pend_ff;
      tmo_in      = tmo_ff;
      idx_in      = idx_ff;
      ev_valid_in = ev_valid_ff;
      ev_idx_in   = ev_idx_ff;
      found_in    = found_ff;
      cnt_in      = cnt_ff;
      hb_valid_in = hb_valid_ff;
      hb_event_in = hb_event_ff;
      hb_slot_in  = hb_slot_ff;
      hb_id_in    = hb_id_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_event_in = rsp_event_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.load) begin
         kind_in     = req_kind;
         per_in      = req_period;
         id_in       = req_handler_id;
         idx_in      = '0;
         ev_valid_in = 1'b0;
         found_in    = 1'b0;
         cnt_in      = '0;
         hb_valid_in = 1'b0;
         if (req_kind == sw_tmr_pkg::KIND_TICK) tick_in = tick_ff + 32'd1;
      end

      if (advance) begin
         ev_valid_in = rd_issue;
         ev_idx_in   = idx_ff[IW-1:0];
         if (rd_issue) idx_in = idx_ff + CW'(1);
      end

      if (ev_fire) begin
         if (add_hit) begin
            valid_in[ev_idx_ff] = 1'b1;
            pend_in[ev_idx_ff]  = 1'b0;
            tmo_in[ev_idx_ff]   = (kind_ff == sw_tmr_pkg::KIND_ADD_TMO);
            found_in            = 1'b1;
         end
         if (stop_hit) begin
            valid_in[ev_idx_ff] = 1'b0;
            pend_in[ev_idx_ff]  = 1'b0;
            tmo_in[ev_idx_ff]   = 1'b0;
            found_in            = 1'b1;
         end
         if (pend_set) pend_in[ev_idx_ff] = 1'b1;
         if (pend_clr) pend_in[ev_idx_ff] = 1'b0;
         if (res_hit) begin
            cnt_in      = cnt_ff + sw_tmr_pkg::CNT_W'(1);
            hb_valid_in = 1'b1;
            hb_event_in = res_event;
            hb_slot_in  = CW'(ev_idx_ff);
            hb_id_in    = res_id;
         end
      end

      if (cmd.finish && !found_ff && is_add_stop) begin
         hb_valid_in = 1'b1;
         hb_event_in = (kind_ff == sw_tmr_pkg::KIND_STOP) ? sw_tmr_pkg::EV_STOP_MISS
                                                          : sw_tmr_pkg::EV_ADD_REJECT;
         hb_slot_in  = SLOT_NONE;
         hb_id_in    = 8'd0;
      end

      if (flush_push) hb_valid_in = 1'b0;

      if (scan_push || flush_push) begin
         rsp_valid_in = 1'b1;
         rsp_event_in = hb_event_ff;
         rsp_slot_in  = hb_slot_ff;
         rsp_id_in    = hb_id_ff;
         rsp_last_in  = flush_push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= 32'd0;
         valid_ff     <= '0;
         pend_ff      <= '0;
         tmo_ff       <= '0;
         idx_ff       <= '0;
         ev_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         cnt_ff       <= '0;
         hb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tick_ff      <= tick_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         tmo_ff       <= tmo_in;
         idx_ff       <= idx_in;
         ev_valid_ff  <= ev_valid_in;
         found_ff     <= found_in;
         cnt_ff       <= cnt_in;
         hb_valid_ff  <= hb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      per_ff       <= per_in;
      id_ff        <= id_in;
      ev_idx_ff    <= ev_idx_in;
      hb_event_ff  <= hb_event_in;
      hb_slot_ff   <= hb_slot_in;
      hb_id_ff     <= hb_id_in;
      rsp_event_ff <= rsp_event_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // slot memories: one read port on the scan address, writes at the evaluated slot
   always_ff @(posedge clock) begin
      if (rd_issue) begin
         owner_rd_ff <= owner_mem[idx_ff[IW-1:0]];
         per_rd_ff   <= per_mem[idx_ff[IW-1:0]];
         ref_rd_ff   <= ref_mem[idx_ff[IW-1:0]];
      end
      if (ev_fire && add_hit) begin
         owner_mem[ev_idx_ff] <= id_ff;
         per_mem[ev_idx_ff]   <= per_ff;
      end
      if (ev_fire && ref_we) begin
         ref_mem[ev_idx_ff] <= ref_wd;
      end
   end

   assign status.scan_done = (idx_ff == SLOT_NONE) && !ev_valid_ff;
   assign status.hb_valid  = hb_valid_ff;
   assign status.out_free  = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_fired_id  = rsp_id_ff;
   assign rsp_last      = rsp_last_ff;

   `SW_TMR_ASSERT_NOW(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= sw_tmr_pkg::RESULT_CAP)
   `SW_TMR_ASSERT_NOW(a_single_match, clock, reset, found_ff, cnt_ff == sw_tmr_pkg::CNT_W'(1))
   `SW_TMR_ASSERT_NOW(a_ev_behind_idx, clock, reset, ev_valid_ff, CW'(ev_idx_ff) < idx_ff)
   `SW_TMR_ASSERT_NEXT(a_res_held, clock, reset, ev_fire && res_hit, hb_valid_ff)

endmodule

@@ src/software_timer_slot_table.sv @@
// Timer slot table with SLOTS slots and a wrapping 32-bit tick counter.
// Request channel (req_valid/req_stall): kind, period, handler_id. Kinds are
// tick, add periodic, add timeout, stop and run pending; one request is in work
// at a time and req_stall stays high until its last result is in the output
// register.
// Response channel (rsp_valid/rsp_stall): event_res, slot, fired_id, last.
// Add and stop give exactly one response; tick and run give zero to eight,
// with last set on the final one. A result is held back one step so that last
// is known when it leaves.
// Each request scans the slots once through a slot memory with one read port,
// one slot per cycle while the scan is not waiting; its final response enters
// the output register in the cycle in which req_stall goes low again, and an
// earlier response leaves when the next result is found.
// A stalled response holds its register; the scan waits only when a further
// result is ready, the hold stage is full and the output register is full and stalled.
// Reset (synchronous, active high) clears the tick counter, frees every slot
// and empties the output; no clearing pass is needed.
module software_timer_slot_table #(
   parameter int SLOTS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_kind,
   input  logic [31:0]                req_period,
   input  logic [7:0]                 req_handler_id,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_event_res,
   output logic [$clog2(SLOTS+1)-1:0] rsp_slot,
   output logic [7:0]                 rsp_fired_id,
   output logic                       rsp_last
);

   sw_tmr_pkg::cmd_type    cmd;
   sw_tmr_pkg::status_type status;

   sw_tmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sw_tmr_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_kind),
      .req_period     (req_period),
      .req_handler_id (req_handler_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_res  (rsp_event_res),
      .rsp_slot       (rsp_slot),
      .rsp_fired_id   (rsp_fired_id),
      .rsp_last       (rsp_last)
   );

endmodule
